// ===== sv/bmsi_pkg.sv =====
// Package for the bank mapper with scanline IRQ: types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package bmsi_pkg;
   localparam int MAX_PRG_BANKS = 64;
   localparam int MAX_CHR_BANKS = 256;

   typedef enum logic [1:0] {
      KIND_PRG_READ  = 2'd0,
      KIND_PRG_WRITE = 2'd1,
      KIND_CHR_READ  = 2'd2,
      KIND_CHR_WRITE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      TGT_NONE  = 3'd0,
      TGT_ZERO  = 3'd1,
      TGT_FF    = 3'd2,
      TGT_PRG   = 3'd3,
      TGT_RAM   = 3'd4,
      TGT_CHR   = 3'd5
   } target_type;

   localparam logic [0:0] REG_PRG_COUNT = 1'd0;
   localparam logic [0:0] REG_CHR_COUNT = 1'd1;

   // mapper register picked by {addr[14:13], addr[0]} for program writes at 0x8000 and up
   localparam logic [2:0] MREG_SELECT      = 3'b000;
   localparam logic [2:0] MREG_BANK_DATA   = 3'b001;
   localparam logic [2:0] MREG_MIRROR      = 3'b010;
   localparam logic [2:0] MREG_PROTECT     = 3'b011;
   localparam logic [2:0] MREG_IRQ_LATCH   = 3'b100;
   localparam logic [2:0] MREG_IRQ_RELOAD  = 3'b101;
   localparam logic [2:0] MREG_IRQ_DISABLE = 3'b110;
   localparam logic [2:0] MREG_IRQ_ENABLE  = 3'b111;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
   } item_type;

   typedef struct packed {
      logic [2:0]  target;
      logic [18:0] offset;
      logic        mem_write;
      logic        irq_pulse;
      logic        mirror;
   } result_type;
endpackage

// ===== sv/bmsi_queue.sv =====
// Two-entry queue between front and back parts.
// Depends on bmsi_pkg.
`timescale 1ns / 1ps
module bmsi_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bmsi_pkg::item_type  in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output bmsi_pkg::item_type  out_item
);
   bmsi_pkg::item_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_item;
      end
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 && !push) |=> !out_valid)
      else $error("queue invented an item");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> !in_ready)
      else $error("queue lost fullness");
endmodule

// ===== sv/bmsi_back.sv =====
// Back part: mapper registers, IRQ counter, address translation, output register.
// Depends on bmsi_pkg.
`timescale 1ns / 1ps
module bmsi_back #(
   parameter int MAX_PRG = bmsi_pkg::MAX_PRG_BANKS,
   parameter int MAX_CHR = bmsi_pkg::MAX_CHR_BANKS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [6:0]           prg_count,
   input  logic [8:0]           chr_count,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bmsi_pkg::item_type   in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bmsi_pkg::result_type out_res
);
   logic [7:0] bank_select_ff, ram_protect_ff, irq_latch_ff, line_counter_ff;
   logic [7:0] bank_regs_ff [8];
   logic       mirror_ff, irq_reload_ff, irq_enabled_ff, last_a12_ff;
   logic       out_valid_ff;
   bmsi_pkg::result_type out_res_ff;

   // bank remainders, rebuilt one restoring step per cycle
   logic [7:0] cwork_ff [8];
   logic [5:0] pwork_ff [2];
   logic [3:0] step_ff;
   logic       dirty_ff;
   logic [6:0] prg_n_ff;
   logic [8:0] chr_n_ff;

   logic [6:0] prg_n;
   logic [8:0] chr_n;
   logic       take;
   logic [15:0] a;
   logic [7:0]  d;
   bmsi_pkg::result_type res;
   logic [5:0] r6, r7, pbank;
   logic [8:0] cbank;
   logic [2:0] cslot;
   logic       rise;
   logic [7:0] cnt_next;
   logic [2:0] bsel;
   logic [2:0] mreg;
   logic [7:0] craw [8];
   logic [2:0] shift;
   logic [16:0] cdiv;
   logic [12:0] pdiv;
   logic       load, cache_ok, bank_wr;

   always_comb begin
      prg_n = (prg_count < 7'd2) ? 7'd2 :
              (prg_count > 7'(MAX_PRG)) ? 7'(MAX_PRG) : prg_count;
      chr_n = (chr_count < 9'd1) ? 9'd1 :
              (chr_count > 9'(MAX_CHR)) ? 9'(MAX_CHR) : chr_count;
   end

   assign load      = dirty_ff || (prg_n != prg_n_ff) || (chr_n != chr_n_ff);
   assign cache_ok  = !load && (step_ff == 4'd0);
   assign in_ready  = cache_ok && (!out_valid_ff || out_ready);
   assign take      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;
   assign a = in_item.addr;
   assign d = in_item.data;
   assign bsel = bank_select_ff[2:0];
   assign mreg = {a[14:13], a[0]};
   assign bank_wr = take && in_item.kind == bmsi_pkg::KIND_PRG_WRITE && a[15]
                    && mreg == bmsi_pkg::MREG_BANK_DATA;
   assign shift = 3'(step_ff - 4'd1);
   assign cdiv = {8'd0, chr_n_ff} << shift;
   assign pdiv = {6'd0, prg_n_ff} << shift;

   always_comb begin
      craw[0] = {bank_regs_ff[0][7:1], 1'b0};
      craw[1] = {bank_regs_ff[0][7:1], 1'b1};
      craw[2] = {bank_regs_ff[1][7:1], 1'b0};
      craw[3] = {bank_regs_ff[1][7:1], 1'b1};
      craw[4] = bank_regs_ff[2];
      craw[5] = bank_regs_ff[3];
      craw[6] = bank_regs_ff[4];
      craw[7] = bank_regs_ff[5];
   end

   always_comb begin
      r6 = pwork_ff[0];
      r7 = pwork_ff[1];
      case (a[14:13])
         2'd0: pbank = bank_select_ff[6] ? 6'(prg_n - 7'd2) : r6;
         2'd1: pbank = r7;
         2'd2: pbank = bank_select_ff[6] ? r6 : 6'(prg_n - 7'd2);
         default: pbank = 6'(prg_n - 7'd1);
      endcase
      cslot = a[12:10] ^ {bank_select_ff[7], 2'b00};
      cbank = {1'b0, cwork_ff[cslot]};
      rise = !last_a12_ff && a[12];
      cnt_next = (line_counter_ff == 8'd0 || irq_reload_ff) ? irq_latch_ff
                                                          : line_counter_ff - 8'd1;
      res = '0;
      res.mirror = mirror_ff;
      case (bmsi_pkg::kind_type'(in_item.kind))
         bmsi_pkg::KIND_PRG_READ: begin
            if (a < 16'h6000) res.target = bmsi_pkg::TGT_ZERO;
            else if (!a[15]) begin
               if (ram_protect_ff[7]) begin
                  res.target = bmsi_pkg::TGT_RAM;
                  res.offset = {6'd0, a[12:0]};
               end else res.target = bmsi_pkg::TGT_FF;
            end else begin
               res.target = bmsi_pkg::TGT_PRG;
               res.offset = {pbank, a[12:0]};
            end
         end
         bmsi_pkg::KIND_PRG_WRITE: begin
            if (a[15]) begin
               if (mreg == bmsi_pkg::MREG_MIRROR) res.mirror = d[0];
            end else if (a >= 16'h6000 && ram_protect_ff[7] && !ram_protect_ff[6]) begin
               res.target = bmsi_pkg::TGT_RAM;
               res.offset = {6'd0, a[12:0]};
               res.mem_write = 1'b1;
            end
         end
         bmsi_pkg::KIND_CHR_READ: begin
            res.irq_pulse = rise && cnt_next == 8'd0 && irq_enabled_ff;
            if (a < 16'h2000) begin
               res.target = bmsi_pkg::TGT_CHR;
               res.offset = {cbank, a[9:0]};
            end else res.target = bmsi_pkg::TGT_ZERO;
         end
         default: begin
            if (a < 16'h2000) begin
               res.target = bmsi_pkg::TGT_CHR;
               res.offset = {cbank, a[9:0]};
               res.mem_write = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b1;
         step_ff <= 4'd0;
         prg_n_ff <= 7'd0;
         chr_n_ff <= 9'd0;
      end else if (load) begin
         for (int k = 0; k < 8; k++) cwork_ff[k] <= craw[k];
         pwork_ff[0] <= bank_regs_ff[6][5:0];
         pwork_ff[1] <= bank_regs_ff[7][5:0];
         prg_n_ff <= prg_n;
         chr_n_ff <= chr_n;
         step_ff <= 4'd8;
         dirty_ff <= 1'b0;
      end else if (step_ff != 4'd0) begin
         for (int k = 0; k < 8; k++) begin
            if ({9'd0, cwork_ff[k]} >= cdiv) cwork_ff[k] <= cwork_ff[k] - cdiv[7:0];
         end
         for (int k = 0; k < 2; k++) begin
            if ({7'd0, pwork_ff[k]} >= pdiv) pwork_ff[k] <= pwork_ff[k] - pdiv[5:0];
         end
         step_ff <= step_ff - 4'd1;
      end else if (bank_wr) begin
         dirty_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) out_res_ff <= res;
      if (reset) begin
         out_valid_ff <= 1'b0;
         bank_select_ff <= '0;
         for (int i = 0; i < 8; i++) bank_regs_ff[i] <= '0;
         ram_protect_ff <= '0;
         mirror_ff <= 1'b0;
         irq_latch_ff <= '0;
         irq_reload_ff <= 1'b0;
         irq_enabled_ff <= 1'b1;
         line_counter_ff <= '0;
         last_a12_ff <= 1'b0;
      end else begin
         if (take) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
         if (take && in_item.kind == bmsi_pkg::KIND_CHR_READ) begin
            last_a12_ff <= a[12];
            if (rise) begin
               line_counter_ff <= cnt_next;
               if (line_counter_ff == 8'd0 || irq_reload_ff) irq_reload_ff <= 1'b0;
            end
         end
         if (take && in_item.kind == bmsi_pkg::KIND_PRG_WRITE && a[15]) begin
            case (mreg)
               bmsi_pkg::MREG_SELECT: bank_select_ff <= d;
               bmsi_pkg::MREG_BANK_DATA:
                  bank_regs_ff[bsel] <= (bsel <= 3'd1) ? {d[7:1], 1'b0} : d;
               bmsi_pkg::MREG_MIRROR: mirror_ff <= d[0];
               bmsi_pkg::MREG_PROTECT: ram_protect_ff <= d;
               bmsi_pkg::MREG_IRQ_LATCH: irq_latch_ff <= d;
               bmsi_pkg::MREG_IRQ_RELOAD: irq_reload_ff <= 1'b1;
               bmsi_pkg::MREG_IRQ_DISABLE: irq_enabled_ff <= 1'b0;
               default: irq_enabled_ff <= 1'b1;
            endcase
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> $stable(out_res_ff))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_res_ff.target <= bmsi_pkg::TGT_CHR))
      else $error("bad target code");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.mem_write) |->
      (out_res_ff.target == bmsi_pkg::TGT_RAM || out_res_ff.target == bmsi_pkg::TGT_CHR))
      else $error("write to a constant target");
endmodule

// ===== sv/bank_mapper_scanline_irq.sv =====
// Bank mapper with scanline IRQ. An accepted request passes through the two-entry queue,
// then the back-part output register, before rsp_tvalid rises. Throughput: one item per cycle
// while rsp_tready is high, except an input stall after a bank data write or a bank-count
// change while the bank remainders are rebuilt, one restoring step per cycle.
// Synchronous active-high reset clears queue, mapper registers (IRQ enabled), sets bank
// counts to 64 and 256 and rebuilds the remainders. Depends on bmsi_pkg, bmsi_queue, bmsi_back.
`timescale 1ns / 1ps
module bank_mapper_scanline_irq #(
   parameter int MAX_PRG = bmsi_pkg::MAX_PRG_BANKS,
   parameter int MAX_CHR = bmsi_pkg::MAX_CHR_BANKS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // bus_address[15:0], write_data[23:16]
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // target[2:0], phys_offset[21:3], mem_write[22], irq_pulse[23]
   output logic        rsp_tuser,   // mirror_horizontal
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [6:0] prg_count_ff;
   logic [8:0] chr_count_ff;
   bmsi_pkg::item_type in_item, q_item;
   bmsi_pkg::result_type res;
   logic q_valid, q_ready;

   assign csr_pready = 1'b1;
   assign in_item.kind = req_tuser;
   assign in_item.addr = req_tdata[15:0];
   assign in_item.data = req_tdata[23:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= 7'd64;
         chr_count_ff <= 9'd256;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == bmsi_pkg::REG_PRG_COUNT) prg_count_ff <= csr_pwdata[6:0];
         else chr_count_ff <= csr_pwdata[8:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == bmsi_pkg::REG_PRG_COUNT) csr_prdata = {25'd0, prg_count_ff};
      else csr_prdata = {23'd0, chr_count_ff};
   end

   bmsi_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   bmsi_back #(.MAX_PRG(MAX_PRG), .MAX_CHR(MAX_CHR)) u_back (
      .clock(clock), .reset(reset),
      .prg_count(prg_count_ff), .chr_count(chr_count_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {res.irq_pulse, res.mem_write, res.offset, res.target};
   assign rsp_tuser = res.mirror;
endmodule

// ===== test/tb_bank_mapper_scanline_irq.sv =====
// Testbench for bank_mapper_scanline_irq: drives bus accesses and bank-count writes,
// predicts each result from a model of the mapper state and checks it in order.
// Depends on bmsi_pkg and the RTL of bank_mapper_scanline_irq.
`timescale 1ns / 1ps
module tb_bank_mapper_scanline_irq;
   import bmsi_pkg::*;

   class mapper_scoreboard;
      logic [6:0] prg_count;
      logic [8:0] chr_count;
      logic [7:0] sel;
      logic [7:0] banks [8];
      logic [7:0] protect;
      logic       mirror;
      logic [7:0] latch;
      logic       reload;
      logic       enabled;
      logic [7:0] counter;
      logic       a12;
      result_type pending [$];
      int         errors;

      function void clear();
         prg_count = 7'd64;
         chr_count = 9'd256;
         sel = 0;
         foreach (banks[i]) banks[i] = 0;
         protect = 0;
         mirror = 0;
         latch = 0;
         reload = 0;
         enabled = 1;
         counter = 0;
         a12 = 0;
         pending.delete();
         errors = 0;
      endfunction

      function int prg_n();
         if (prg_count < 2) return 2;
         if (prg_count > MAX_PRG_BANKS) return MAX_PRG_BANKS;
         return prg_count;
      endfunction

      function int chr_n();
         if (chr_count < 1) return 1;
         if (chr_count > MAX_CHR_BANKS) return MAX_CHR_BANKS;
         return chr_count;
      endfunction

      function int prg_bank(int slot);
         int n, r6, r7;
         bit swap;
         n = prg_n();
         r6 = (banks[6] & 8'h3F) % n;
         r7 = (banks[7] & 8'h3F) % n;
         swap = sel[6];
         case (slot & 3)
            0: return swap ? n - 2 : r6;
            1: return r7;
            2: return swap ? r6 : n - 2;
            default: return n - 1;
         endcase
      endfunction

      function int chr_bank(int slot);
         int raw;
         slot &= 7;
         if (sel[7]) slot ^= 4;
         case (slot)
            0: raw = banks[0] & 8'hFE;
            1: raw = banks[0] | 8'h01;
            2: raw = banks[1] & 8'hFE;
            3: raw = banks[1] | 8'h01;
            default: raw = banks[slot - 2];
         endcase
         return raw % chr_n();
      endfunction

      function void note_item(kind_type kind, logic [15:0] addr, logic [7:0] data);
         result_type r;
         logic prev;
         r = '0;
         r.target = TGT_NONE;
         case (kind)
            KIND_PRG_READ:
               if (addr < 16'h6000) r.target = TGT_ZERO;
               else if (addr < 16'h8000) begin
                  if (protect[7]) begin
                     r.target = TGT_RAM;
                     r.offset = 19'(addr - 16'h6000);
                  end else r.target = TGT_FF;
               end else begin
                  r.target = TGT_PRG;
                  r.offset = 19'(prg_bank((addr - 16'h8000) / 16'h2000) * 32'h2000
                                 + (addr & 16'h1FFF));
               end
            KIND_PRG_WRITE:
               if (addr >= 16'h8000) begin
                  case (addr & 16'hE001)
                     16'h8000: sel = data;
                     16'h8001: banks[sel[2:0]] = (sel[2:0] <= 1) ? (data & 8'hFE) : data;
                     16'hA000: mirror = data[0];
                     16'hA001: protect = data;
                     16'hC000: latch = data;
                     16'hC001: reload = 1;
                     16'hE000: enabled = 0;
                     default: enabled = 1;
                  endcase
               end else if (addr >= 16'h6000 && protect[7] && !protect[6]) begin
                  r.target = TGT_RAM;
                  r.offset = 19'(addr - 16'h6000);
                  r.mem_write = 1;
               end
            KIND_CHR_READ: begin
               prev = a12;
               a12 = addr[12];
               if (!prev && a12) begin
                  if (counter == 0 || reload) begin
                     reload = 0;
                     counter = latch;
                  end else counter = counter - 1;
                  if (counter == 0 && enabled) r.irq_pulse = 1;
               end
               if (addr < 16'h2000) begin
                  r.target = TGT_CHR;
                  r.offset = 19'(chr_bank(addr / 16'h400) * 32'h400 + (addr & 16'h3FF));
               end else r.target = TGT_ZERO;
            end
            default:
               if (addr < 16'h2000) begin
                  r.target = TGT_CHR;
                  r.offset = 19'(chr_bank(addr / 16'h400) * 32'h400 + (addr & 16'h3FF));
                  r.mem_write = 1;
               end
         endcase
         r.mirror = mirror;
         pending.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want.target !== got.target)
            $display("%0t: target expected %0d actual %0d", $time, want.target, got.target);
         if (want.offset !== got.offset)
            $display("%0t: offset expected %h actual %h", $time, want.offset, got.offset);
         if (want.mem_write !== got.mem_write)
            $display("%0t: mem_write expected %b actual %b", $time, want.mem_write,
                     got.mem_write);
         if (want.irq_pulse !== got.irq_pulse)
            $display("%0t: irq_pulse expected %b actual %b", $time, want.irq_pulse,
                     got.irq_pulse);
         if (want.mirror !== got.mirror)
            $display("%0t: mirror expected %b actual %b", $time, want.mirror, got.mirror);
         if (want !== got) errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // bus_address, write_data
   logic [1:0]  req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // target, phys_offset, mem_write, irq_pulse
   logic        rsp_tuser;   // mirror_horizontal
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mapper_scoreboard board;
   int send_idle;
   int recv_stall;
   int hold_cycles;

   bank_mapper_scanline_irq u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   // result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(result_type'({rsp_tdata[2:0], rsp_tdata[21:3],
                                             rsp_tdata[22], rsp_tdata[23], rsp_tuser}));
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (addr == 3'(REG_PRG_COUNT) * 4) board.prg_count = value[6:0];
      else board.chr_count = value[8:0];
   endtask

   task automatic send_item(kind_type kind, logic [15:0] addr, logic [7:0] data);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(kind, addr, data);
   endtask

   task automatic drain();
      int guard;
      req_tvalid <= 0;
      guard = 0;
      while (board.pending.size() > 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic reg_write(logic [15:0] addr, logic [7:0] data);
      send_item(KIND_PRG_WRITE, addr, data);
   endtask

   // mostly well-formed mapper traffic with random content
   task automatic random_items(int count);
      int pick;
      logic [15:0] a;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         a = $urandom;
         if (pick < 15) begin
            a = 16'h8000 | ($urandom_range(7) << 13) | $urandom_range(1);
            a = a | ($urandom & 16'h1FFE);
            reg_write(a, $urandom);
         end else if (pick < 30) begin
            send_item(KIND_PRG_READ, a, $urandom);
         end else if (pick < 40) begin
            send_item(KIND_PRG_WRITE, $urandom_range(16'h7FFF), $urandom);
         end else if (pick < 85) begin
            if ($urandom_range(9) == 0) a = $urandom;
            else a = $urandom_range(16'h1FFF);
            send_item(KIND_CHR_READ, a, $urandom);
         end else begin
            send_item(KIND_CHR_WRITE, a, $urandom);
         end
      end
   endtask

   initial begin
      board = new();
      board.clear();
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      send_idle = 0;
      recv_stall = 0;
      hold_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every kind, range edges, registers and counter
      send_item(KIND_PRG_READ, 16'h0000, 8'h00);
      send_item(KIND_PRG_READ, 16'h6000, 8'h00);
      send_item(KIND_PRG_WRITE, 16'h5FFF, 8'hFF);
      reg_write(16'hA001, 8'h80);
      send_item(KIND_PRG_WRITE, 16'h7FFF, 8'hA5);
      send_item(KIND_PRG_READ, 16'h7FFF, 8'h00);
      reg_write(16'hA001, 8'hC0);
      send_item(KIND_PRG_WRITE, 16'h6000, 8'h5A);
      reg_write(16'h8000, 8'hC0);
      reg_write(16'h8001, 8'hFF);
      reg_write(16'h8000, 8'h46);
      reg_write(16'hFFFF, 8'h3F);
      send_item(KIND_PRG_READ, 16'h8000, 8'h00);
      send_item(KIND_PRG_READ, 16'hFFFF, 8'h00);
      send_item(KIND_CHR_READ, 16'h0000, 8'h00);
      send_item(KIND_CHR_WRITE, 16'h1FFF, 8'hFF);
      send_item(KIND_CHR_WRITE, 16'h2000, 8'hFF);
      reg_write(16'hA000, 8'hFF);
      reg_write(16'hC000, 8'h02);
      reg_write(16'hC001, 8'h00);
      for (int i = 0; i < 4; i++) begin
         send_item(KIND_CHR_READ, 16'h0FFF, 8'h00);
         send_item(KIND_CHR_READ, 16'hF000, 8'h00);
      end
      reg_write(16'hE000, 8'h00);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 69; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 69; end
            default: begin send_idle = 30; recv_stall = 30; end
         endcase
         case (phase)
            0: begin csr_write(3'(REG_PRG_COUNT) * 4, 2); csr_write(3'(REG_CHR_COUNT) * 4, 1); end
            1: begin csr_write(3'(REG_PRG_COUNT) * 4, 64); csr_write(3'(REG_CHR_COUNT) * 4, 256); end
            2: begin csr_write(3'(REG_PRG_COUNT) * 4, 0); csr_write(3'(REG_CHR_COUNT) * 4, 0); end
            3: begin csr_write(3'(REG_PRG_COUNT) * 4, 127); csr_write(3'(REG_CHR_COUNT) * 4, 511); end
            default: begin
               csr_write(3'(REG_PRG_COUNT) * 4, $urandom_range(127));
               csr_write(3'(REG_CHR_COUNT) * 4, $urandom_range(511));
            end
         endcase
         if (phase == 0) hold_cycles = 300;
         random_items(220);
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== files.f =====
sv/bmsi_pkg.sv
sv/bmsi_queue.sv
sv/bmsi_back.sv
sv/bank_mapper_scanline_irq.sv
test/tb_bank_mapper_scanline_irq.sv
